// File: rtl/core/gva_pkg.sv
// ----------------------------------------------------------------------------
// gva_pkg
// Shared types and constants for the vertex attribute converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gva_pkg;

  // Number of quotient bits, which is also the number of divider stages.
  localparam int QW = 48;
  // Signed width of a texel-space coordinate after the divide.
  localparam int PW = QW + 1;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_TEX_FLAGS   = 3'd0,
    REG_TEX_FUNC    = 3'd1,
    REG_WRAP_MODES  = 3'd2,
    REG_SIZE_LOG2   = 3'd3,
    REG_REGION_U    = 3'd4,
    REG_REGION_V    = 3'd5,
    REG_ALPHA_EXP   = 3'd6,
    REG_ALPHA_BLEND = 3'd7
  } reg_idx_t;

  // Texture function codes. Both highlight modes behave as modulate.
  localparam logic [1:0] TFX_MODULATE   = 2'd0;
  localparam logic [1:0] TFX_DECAL      = 2'd1;
  localparam logic [1:0] TFX_HIGHLIGHT  = 2'd2;
  localparam logic [1:0] TFX_HIGHLIGHT2 = 2'd3;

  // Wrap mode codes.
  typedef enum logic [1:0] {
    WRAP_REPEAT     = 2'd0,
    WRAP_CLAMP      = 2'd1,
    WRAP_REG_CLAMP  = 2'd2,
    WRAP_REG_REPEAT = 2'd3
  } wrap_t;

  // Attributes that ride alongside the divide.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        textured;
  } side_t;

  // One divider lane: partial remainder, dividend/quotient shifter, divisor, sign.
  typedef struct packed {
    logic [31:0]   rem;
    logic [QW-1:0] nq;
    logic [31:0]   d;
    logic          neg;
  } lane_t;

  // Per-axis wrap configuration.
  typedef struct packed {
    wrap_t       mode;
    logic [3:0]  lg;
    logic [19:0] region;
  } axis_cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/gva_div.sv
// ----------------------------------------------------------------------------
// gva_div
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gva_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_vld,
  input  wire gva_pkg::side_t  in_side,
  input  wire gva_pkg::lane_t  in_u,
  input  wire gva_pkg::lane_t  in_v,
  output logic                 out_vld,
  output gva_pkg::side_t       out_side,
  output logic signed [gva_pkg::PW-1:0] out_pu,
  output logic signed [gva_pkg::PW-1:0] out_pv
);
  import gva_pkg::*;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  function automatic lane_t div_step(input lane_t l);
    lane_t       o;
    logic [32:0] trial;
    logic        qb;
    trial = {l.rem, l.nq[QW-1]};
    qb    = (trial >= {1'b0, l.d});
    o     = l;
    o.rem = qb ? 32'(trial - {1'b0, l.d}) : trial[31:0];
    o.nq  = {l.nq[QW-2:0], qb};
    return o;
  endfunction

  logic        vld_r  [QW];
  side_t       side_r [QW];
  lane_t       u_r    [QW];
  lane_t       v_r    [QW];

  // Valid bits of the stage chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < QW; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Payload of the stage chain.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      u_r[0]    <= div_step(in_u);
      v_r[0]    <= div_step(in_v);
      for (int i = 1; i < QW; i++) begin
        side_r[i] <= side_r[i-1];
        u_r[i]    <= div_step(u_r[i-1]);
        v_r[i]    <= div_step(v_r[i-1]);
      end
    end
  end

  // Apply the quotient sign.
  assign out_vld  = vld_r[QW-1];
  assign out_side = side_r[QW-1];
  assign out_pu   = u_r[QW-1].neg ? -$signed({1'b0, u_r[QW-1].nq})
                                  :  $signed({1'b0, u_r[QW-1].nq});
  assign out_pv   = v_r[QW-1].neg ? -$signed({1'b0, v_r[QW-1].nq})
                                  :  $signed({1'b0, v_r[QW-1].nq});

endmodule

`default_nettype wire

// File: rtl/core/gva_wrap.sv
// ----------------------------------------------------------------------------
// gva_wrap
// Size normalization, wrap modes and saturation in two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gva_wrap (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_vld,
  input  wire gva_pkg::side_t     in_side,
  input  wire logic signed [gva_pkg::PW-1:0] in_pu,
  input  wire logic signed [gva_pkg::PW-1:0] in_pv,
  input  wire gva_pkg::axis_cfg_t cfg_u,
  input  wire gva_pkg::axis_cfg_t cfg_v,
  output logic                    out_vld,
  output gva_pkg::side_t          out_side,
  output logic signed [31:0]      out_u,
  output logic signed [31:0]      out_v
);
  import gva_pkg::*;

  // Truncating divide by 2^k for a signed value.
  function automatic logic signed [PW-1:0] trunc_shr(input logic signed [PW-1:0] p,
                                                     input logic [4:0] k);
    logic [PW-1:0] bias;
    bias = p[PW-1] ? ((PW'(1) << k) - PW'(1)) : '0;
    return (p + $signed(bias)) >>> k;
  endfunction

  // Wrap one axis and saturate to 32 bits.
  function automatic logic signed [31:0] wrap_axis(input logic signed [PW-1:0] c,
                                                   input logic [9:0] texel,
                                                   input axis_cfg_t cf);
    logic [9:0]              mn;
    logic [9:0]              mx;
    logic [25:0]             lo;
    logic [25:0]             hi;
    logic [9:0]              rr;
    logic signed [PW-1:0]    res;
    mn  = cf.region[9:0];
    mx  = cf.region[19:10];
    lo  = {mn, 16'b0} >> cf.lg;
    hi  = {mx, 16'b0} >> cf.lg;
    rr  = (texel & mn) | mx;
    res = c;
    case (cf.mode)
      WRAP_REPEAT: res = $signed({{(PW-16){1'b0}}, c[15:0]});
      WRAP_CLAMP: begin
        if (c < 0)                       res = '0;
        else if (c > $signed(PW'(65536))) res = $signed(PW'(65536));
      end
      WRAP_REG_CLAMP: begin
        if (c < $signed(PW'(lo)))        res = $signed(PW'(lo));
        else if (c > $signed(PW'(hi)))   res = $signed(PW'(hi));
      end
      WRAP_REG_REPEAT: res = $signed(PW'({rr, 16'b0} >> cf.lg));
      default: res = c;
    endcase
    if (res > $signed(PW'(32'h7FFF_FFFF)))       return 32'sh7FFF_FFFF;
    else if (res < -$signed(PW'(33'h1_0000_0000) >>> 1)) return 32'sh8000_0000;
    else return res[31:0];
  endfunction

  logic                 a_vld_r;
  side_t                a_side_r;
  logic signed [PW-1:0] a_cu_r;
  logic signed [PW-1:0] a_cv_r;
  logic [9:0]           a_tu_r;
  logic [9:0]           a_tv_r;
  logic signed [PW-1:0] tu_full;
  logic signed [PW-1:0] tv_full;

  assign tu_full = trunc_shr(in_pu, 5'd16);
  assign tv_full = trunc_shr(in_pv, 5'd16);

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      out_vld <= a_vld_r;
    end
  end

  // Stage A normalizes by the texture size; stage B wraps and saturates.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_side_r <= in_side;
      a_cu_r   <= trunc_shr(in_pu, {1'b0, cfg_u.lg});
      a_cv_r   <= trunc_shr(in_pv, {1'b0, cfg_v.lg});
      a_tu_r   <= tu_full[9:0];
      a_tv_r   <= tv_full[9:0];
      out_side <= a_side_r;
      out_u    <= a_side_r.textured ? wrap_axis(a_cu_r, a_tu_r, cfg_u) : '0;
      out_v    <= a_side_r.textured ? wrap_axis(a_cv_r, a_tv_r, cfg_v) : '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gs_vertex_attribute_convert.sv
// ----------------------------------------------------------------------------
// gs_vertex_attribute_convert
// Converts one graphics-synthesizer vertex into a renderer vertex.
// ----------------------------------------------------------------------------
// Takes one vertex beat per clock unless the pipeline holds. Each accepted
// beat lands in an input register, then passes a 48-stage divider that
// yields one quotient bit per stage for the divide of S and T by Q (by one
// in texel mode), and two stages for size normalization and wrapping. The
// whole pipeline holds when a result waits and out_ready is low. Registers
// are written over the APB port at byte address 4 times the register index
// and should only be changed while no vertex is in flight.
`default_nettype none

module gs_vertex_attribute_convert (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_x_pos,
  input  wire logic [15:0]        in_y_pos,
  input  wire logic [7:0]         in_red_in,
  input  wire logic [7:0]         in_green_in,
  input  wire logic [7:0]         in_blue_in,
  input  wire logic [7:0]         in_alpha_in,
  input  wire logic signed [31:0] in_tex_s,
  input  wire logic signed [31:0] in_tex_t,
  input  wire logic signed [31:0] in_tex_q,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_x_out,
  output logic signed [15:0]      out_y_out,
  output logic [7:0]              out_red_out,
  output logic [7:0]              out_green_out,
  output logic [7:0]              out_blue_out,
  output logic [7:0]              out_alpha_out,
  output logic signed [31:0]      out_u_coord,
  output logic signed [31:0]      out_v_coord
);
  import gva_pkg::*;

  logic [3:0]  tex_flags_r;
  logic [1:0]  tex_func_r;
  logic [3:0]  wrap_modes_r;
  logic [7:0]  size_log2_r;
  logic [19:0] region_u_r;
  logic [19:0] region_v_r;
  logic [15:0] alpha_exp_r;
  logic        alpha_blend_r;
  logic        wr_en;
  reg_idx_t    wr_idx;
  logic        adv;

  // Register file writes.
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign wr_idx     = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_flags_r   <= '0;
      tex_func_r    <= '0;
      wrap_modes_r  <= '0;
      size_log2_r   <= '0;
      region_u_r    <= '0;
      region_v_r    <= '0;
      alpha_exp_r   <= '0;
      alpha_blend_r <= 1'b0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_TEX_FLAGS:   tex_flags_r   <= cfg_pwdata[3:0];
        REG_TEX_FUNC:    tex_func_r    <= cfg_pwdata[1:0];
        REG_WRAP_MODES:  wrap_modes_r  <= cfg_pwdata[3:0];
        REG_SIZE_LOG2:   size_log2_r   <= cfg_pwdata[7:0];
        REG_REGION_U:    region_u_r    <= cfg_pwdata[19:0];
        REG_REGION_V:    region_v_r    <= cfg_pwdata[19:0];
        REG_ALPHA_EXP:   alpha_exp_r   <= cfg_pwdata[15:0];
        REG_ALPHA_BLEND: alpha_blend_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (wr_idx)
      REG_TEX_FLAGS:   cfg_prdata = {28'b0, tex_flags_r};
      REG_TEX_FUNC:    cfg_prdata = {30'b0, tex_func_r};
      REG_WRAP_MODES:  cfg_prdata = {28'b0, wrap_modes_r};
      REG_SIZE_LOG2:   cfg_prdata = {24'b0, size_log2_r};
      REG_REGION_U:    cfg_prdata = {12'b0, region_u_r};
      REG_REGION_V:    cfg_prdata = {12'b0, region_v_r};
      REG_ALPHA_EXP:   cfg_prdata = {16'b0, alpha_exp_r};
      REG_ALPHA_BLEND: cfg_prdata = {31'b0, alpha_blend_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // The whole pipeline moves unless a finished result is held.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Doubling with saturation at 255.
  function automatic logic [7:0] dbl_sat(input logic [7:0] c);
    return c[7] ? 8'hFF : {c[6:0], 1'b0};
  endfunction

  // Positions above 1000.0 wrap down by 2048.0.
  function automatic logic [15:0] wrap_pos(input logic [15:0] p);
    return (p > 16'd16000) ? 16'(p - 16'h8000) : p;
  endfunction

  logic       enabled;
  logic       textured;
  logic       tcc;
  logic       fst;
  logic [7:0] a_sel;
  side_t      side_nxt;
  lane_t      lu_nxt;
  lane_t      lv_nxt;
  logic [31:0] s_mag;
  logic [31:0] t_mag;
  logic [31:0] q_mag;

  assign enabled  = tex_flags_r[0];
  assign textured = tex_flags_r[0] & tex_flags_r[1];
  assign tcc      = tex_flags_r[2];
  assign fst      = tex_flags_r[3];

  // Color, alpha and position conversion.
  always_comb begin
    side_nxt.x        = wrap_pos(in_x_pos);
    side_nxt.y        = wrap_pos(in_y_pos);
    side_nxt.textured = textured;
    a_sel             = in_alpha_in;
    if (textured) begin
      if (tex_func_r == TFX_DECAL) begin
        side_nxt.r = 8'hFF;
        side_nxt.g = 8'hFF;
        side_nxt.b = 8'hFF;
        side_nxt.a = tcc ? 8'hFF : dbl_sat(in_alpha_in);
      end else begin
        side_nxt.r = dbl_sat(in_red_in);
        side_nxt.g = dbl_sat(in_green_in);
        side_nxt.b = dbl_sat(in_blue_in);
        side_nxt.a = dbl_sat(in_alpha_in);
      end
    end else begin
      if (enabled && !tcc) begin
        a_sel = (in_alpha_in == 8'd0) ? alpha_exp_r[7:0] : alpha_exp_r[15:8];
      end
      side_nxt.r = in_red_in;
      side_nxt.g = in_green_in;
      side_nxt.b = in_blue_in;
      side_nxt.a = dbl_sat(a_sel);
    end
    if (!alpha_blend_r) side_nxt.a = 8'hFF;
  end

  // Divider operands: texel mode divides by one, perspective mode by Q.
  always_comb begin
    s_mag = in_tex_s[31] ? 32'(-in_tex_s) : in_tex_s;
    t_mag = in_tex_t[31] ? 32'(-in_tex_t) : in_tex_t;
    q_mag = (in_tex_q == 32'sd0) ? 32'h0001_0000
          : (in_tex_q[31] ? 32'(-in_tex_q) : in_tex_q);
    lu_nxt.rem = '0;
    lv_nxt.rem = '0;
    if (fst) begin
      lu_nxt.nq  = {16'b0, s_mag};
      lv_nxt.nq  = {16'b0, t_mag};
      lu_nxt.d   = 32'd1;
      lv_nxt.d   = 32'd1;
      lu_nxt.neg = in_tex_s[31];
      lv_nxt.neg = in_tex_t[31];
    end else begin
      lu_nxt.nq  = {s_mag, 16'b0};
      lv_nxt.nq  = {t_mag, 16'b0};
      lu_nxt.d   = q_mag;
      lv_nxt.d   = q_mag;
      lu_nxt.neg = in_tex_s[31] ^ in_tex_q[31];
      lv_nxt.neg = in_tex_t[31] ^ in_tex_q[31];
    end
  end

  // Input register stage.
  logic  s0_vld_r;
  side_t s0_side_r;
  lane_t s0_u_r;
  lane_t s0_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r <= side_nxt;
      s0_u_r    <= lu_nxt;
      s0_v_r    <= lv_nxt;
    end
  end

  logic                 d_vld;
  side_t                d_side;
  logic signed [PW-1:0] d_pu;
  logic signed [PW-1:0] d_pv;

  gva_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (s0_vld_r),
    .in_side  (s0_side_r),
    .in_u     (s0_u_r),
    .in_v     (s0_v_r),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_pu   (d_pu),
    .out_pv   (d_pv)
  );

  axis_cfg_t cfg_u;
  axis_cfg_t cfg_v;
  side_t     w_side;

  assign cfg_u = '{mode: wrap_t'(wrap_modes_r[1:0]), lg: size_log2_r[3:0], region: region_u_r};
  assign cfg_v = '{mode: wrap_t'(wrap_modes_r[3:2]), lg: size_log2_r[7:4], region: region_v_r};

  gva_wrap u_wrap (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (d_vld),
    .in_side  (d_side),
    .in_pu    (d_pu),
    .in_pv    (d_pv),
    .cfg_u    (cfg_u),
    .cfg_v    (cfg_v),
    .out_vld  (out_valid),
    .out_side (w_side),
    .out_u    (out_u_coord),
    .out_v    (out_v_coord)
  );

  assign out_x_out     = w_side.x;
  assign out_y_out     = w_side.y;
  assign out_red_out   = w_side.r;
  assign out_green_out = w_side.g;
  assign out_blue_out  = w_side.b;
  assign out_alpha_out = w_side.a;

endmodule

`default_nettype wire

// File: rtl/core/gva_checker.sv
// ----------------------------------------------------------------------------
// gva_checker
// Port-level checks for the vertex attribute converter.
// ----------------------------------------------------------------------------
`default_nettype none

module gva_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cfg_pready
);

  // A result beat is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // A held result stalls the input side.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the pipeline is stalled");

  // With no result pending, the input side is open.
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with an empty output");

  // Nothing comes out right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown after reset");

  // The register port never waits.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind gs_vertex_attribute_convert gva_checker u_gva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

// File: bench/gva_vertex_checker.sv
// ----------------------------------------------------------------------------
// gva_vertex_checker
// Watches the vertex and result channels of the attribute converter,
// predicts every converted vertex from a shadow copy of the registers and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module gva_vertex_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic               cfg_pready,
  input  wire logic [4:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [15:0]        in_x_pos,
  input  wire logic [15:0]        in_y_pos,
  input  wire logic [7:0]         in_red_in,
  input  wire logic [7:0]         in_green_in,
  input  wire logic [7:0]         in_blue_in,
  input  wire logic [7:0]         in_alpha_in,
  input  wire logic signed [31:0] in_tex_s,
  input  wire logic signed [31:0] in_tex_t,
  input  wire logic signed [31:0] in_tex_q,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] out_x_out,
  input  wire logic signed [15:0] out_y_out,
  input  wire logic [7:0]         out_red_out,
  input  wire logic [7:0]         out_green_out,
  input  wire logic [7:0]         out_blue_out,
  input  wire logic [7:0]         out_alpha_out,
  input  wire logic signed [31:0] out_u_coord,
  input  wire logic signed [31:0] out_v_coord,
  output int                      fail_count,
  output int                      pending_count,
  output int                      vertex_count
);
  import gva_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [31:0] u;
    logic [31:0] v;
  } render_vtx_t;

  // Shadow copy of the configuration registers.
  logic [3:0]  sh_flags;
  logic [1:0]  sh_func;
  logic [3:0]  sh_wrap;
  logic [7:0]  sh_size;
  logic [19:0] sh_reg_u;
  logic [19:0] sh_reg_v;
  logic [15:0] sh_aexp;
  logic        sh_blend;

  render_vtx_t expected_vertices[$];

  function automatic logic [7:0] double_sat(logic [7:0] c);
    logic [8:0] d;
    d = {c, 1'b0};
    return d[8] ? 8'hFF : d[7:0];
  endfunction

  function automatic logic [15:0] wrap_screen(logic [15:0] p);
    return (p > 16'd16000) ? p - 16'd32768 : p;
  endfunction

  // Wraps one normalized coordinate; texel is the texel-space value.
  function automatic longint wrap_coord(longint c, longint texel, wrap_t mode,
                                        logic [19:0] region, int lg);
    longint dim, mn, mx, lo, hi, tx;
    dim = longint'(1) << lg;
    mn = region[9:0];
    mx = region[19:10];
    case (mode)
      WRAP_REPEAT: return c & 64'hFFFF;
      WRAP_CLAMP: begin
        if (c < 0) return 0;
        if (c > 65536) return 65536;
        return c;
      end
      WRAP_REG_CLAMP: begin
        lo = (mn * 65536) / dim;
        hi = (mx * 65536) / dim;
        if (c < lo) return lo;
        if (c > hi) return hi;
        return c;
      end
      default: begin
        tx = ((texel / 65536) & mn) | mx;
        return (tx * 65536) / dim;
      end
    endcase
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic render_vtx_t convert_vertex();
    render_vtx_t e;
    logic en, textured, tcc, fst;
    longint s, t, q, ps, pt, cs, ct;
    int tw, th;
    en = sh_flags[0];
    textured = en && sh_flags[1];
    tcc = sh_flags[2];
    fst = sh_flags[3];
    e.x = wrap_screen(in_x_pos);
    e.y = wrap_screen(in_y_pos);
    e.r = in_red_in;
    e.g = in_green_in;
    e.b = in_blue_in;
    e.a = in_alpha_in;
    e.u = '0;
    e.v = '0;
    // Color and alpha per texture function.
    if (textured) begin
      if (sh_func == TFX_DECAL) begin
        e.r = 8'hFF; e.g = 8'hFF; e.b = 8'hFF;
        e.a = tcc ? 8'hFF : double_sat(e.a);
      end else begin
        e.r = double_sat(e.r); e.g = double_sat(e.g);
        e.b = double_sat(e.b); e.a = double_sat(e.a);
      end
    end else begin
      if (en && !tcc)
        e.a = (e.a == 0) ? sh_aexp[7:0] : sh_aexp[15:8];
      e.a = double_sat(e.a);
    end
    if (!sh_blend) e.a = 8'hFF;
    // Texture coordinates.
    if (textured) begin
      tw = sh_size[3:0];
      th = sh_size[7:4];
      s = in_tex_s;
      t = in_tex_t;
      q = in_tex_q;
      if (fst) begin
        ps = s; pt = t;
        cs = s / (longint'(1) << tw);
        ct = t / (longint'(1) << th);
      end else begin
        if (q == 0) q = 65536;
        ps = (s * 65536) / q;
        pt = (t * 65536) / q;
        cs = (s * 65536) / (q * (longint'(1) << tw));
        ct = (t * 65536) / (q * (longint'(1) << th));
      end
      e.u = clip32(wrap_coord(cs, ps, wrap_t'(sh_wrap[1:0]), sh_reg_u, tw));
      e.v = clip32(wrap_coord(ct, pt, wrap_t'(sh_wrap[3:2]), sh_reg_v, th));
    end
    return e;
  endfunction

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending_count = expected_vertices.size();

  always @(posedge clk) begin
    render_vtx_t e;
    if (!rst_n) begin
      sh_flags <= '0; sh_func <= '0; sh_wrap <= '0; sh_size <= '0;
      sh_reg_u <= '0; sh_reg_v <= '0; sh_aexp <= '0; sh_blend <= 1'b0;
    end else begin
      // Register writes update the shadow copy.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_TEX_FLAGS:   sh_flags <= cfg_pwdata[3:0];
          REG_TEX_FUNC:    sh_func <= cfg_pwdata[1:0];
          REG_WRAP_MODES:  sh_wrap <= cfg_pwdata[3:0];
          REG_SIZE_LOG2:   sh_size <= cfg_pwdata[7:0];
          REG_REGION_U:    sh_reg_u <= cfg_pwdata[19:0];
          REG_REGION_V:    sh_reg_v <= cfg_pwdata[19:0];
          REG_ALPHA_EXP:   sh_aexp <= cfg_pwdata[15:0];
          REG_ALPHA_BLEND: sh_blend <= cfg_pwdata[0];
          default: ;
        endcase
      end
      // Predict each accepted vertex beat.
      if (in_valid && in_ready)
        expected_vertices = {expected_vertices, convert_vertex()};
      // Compare each accepted result beat.
      if (out_valid && out_ready) begin
        vertex_count++;
        if (expected_vertices.size() == 0) begin
          $error("result beat with no vertex outstanding");
          fail_count++;
        end else begin
          e = expected_vertices.pop_front();
          compare_field("x_out", e.x, out_x_out[15:0]);
          compare_field("y_out", e.y, out_y_out[15:0]);
          compare_field("red_out", e.r, out_red_out);
          compare_field("green_out", e.g, out_green_out);
          compare_field("blue_out", e.b, out_blue_out);
          compare_field("alpha_out", e.a, out_alpha_out);
          compare_field("u_coord", e.u, out_u_coord[31:0]);
          compare_field("v_coord", e.v, out_v_coord[31:0]);
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    vertex_count = 0;
  end

endmodule

`default_nettype wire

// File: bench/tb_gs_vertex_attribute_convert.sv
// ----------------------------------------------------------------------------
// tb_gs_vertex_attribute_convert
// Drives vertices and register settings into the attribute converter.
// ----------------------------------------------------------------------------
// Each phase programs the registers over APB, then sends directed or random
// vertices with random idling on both channels outside the calm phase. The
// checker beside the block predicts and compares every result beat.
`default_nettype none

module tb_gs_vertex_attribute_convert;
  import gva_pkg::*;

  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  logic in_valid = 1'b0, in_ready;
  logic [15:0] in_x_pos = '0, in_y_pos = '0;
  logic [7:0] in_red_in = '0, in_green_in = '0, in_blue_in = '0, in_alpha_in = '0;
  logic signed [31:0] in_tex_s = '0, in_tex_t = '0, in_tex_q = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [15:0] out_x_out, out_y_out;
  logic [7:0] out_red_out, out_green_out, out_blue_out, out_alpha_out;
  logic signed [31:0] out_u_coord, out_v_coord;
  int fail_count, pending_count, vertex_count;
  bit calm_mode = 1'b0;
  int sent_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gs_vertex_attribute_convert dut (.*);

  gva_vertex_checker checker_i (.*);

  // Result side stalls at random except in the calm stretch.
  always @(posedge clk)
    out_ready <= calm_mode || ($urandom_range(99) >= 23);

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic write_all(logic [3:0] fl, logic [1:0] fn, logic [3:0] wr,
                           logic [7:0] sz, logic [19:0] ru, logic [19:0] rv,
                           logic [15:0] ae, logic bl);
    write_reg(REG_TEX_FLAGS, 32'(fl));
    write_reg(REG_TEX_FUNC, 32'(fn));
    write_reg(REG_WRAP_MODES, 32'(wr));
    write_reg(REG_SIZE_LOG2, 32'(sz));
    write_reg(REG_REGION_U, 32'(ru));
    write_reg(REG_REGION_V, 32'(rv));
    write_reg(REG_ALPHA_EXP, 32'(ae));
    write_reg(REG_ALPHA_BLEND, 32'(bl));
  endtask

  // Sends one vertex beat; idles first now and then. Valid stays high after
  // the beat so that the next one can follow with no gap.
  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [31:0] rgba,
                             logic [31:0] s, logic [31:0] t, logic [31:0] q);
    while (!calm_mode && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_pos <= x; in_y_pos <= y;
    {in_red_in, in_green_in, in_blue_in, in_alpha_in} <= rgba;
    in_tex_s <= s; in_tex_t <= t; in_tex_q <= q;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(2047) << 16 | $urandom_range(65535);
      2: return -($urandom_range(2047) << 16) - $urandom_range(65535);
      default: return $urandom_range(262143) - 131072;
    endcase
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'd65536;
      3: return -(32'($urandom_range(65535)) + 1);
      default: return $urandom_range(262143) + 1;
    endcase
  endfunction

  task automatic send_random();
    send_vertex($urandom(), $urandom(), $urandom(), rand_coord(), rand_coord(), rand_q());
  endtask

  // Drops valid and waits until every result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    write_all(4'($urandom()), 2'($urandom()), 4'($urandom()),
              {4'($urandom_range(15)), 4'($urandom_range(15))},
              20'($urandom()), 20'($urandom()), 16'($urandom()), 1'($urandom()));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: untextured with alpha table, blending on.
    write_all(4'b0001, TFX_MODULATE, {WRAP_REPEAT, WRAP_REPEAT}, 8'h00, 20'h0, 20'h0,
              16'hA05A, 1'b1);
    send_vertex(16'd0, 16'hFFFF, 32'h00000000, 0, 0, 0);
    send_vertex(16'd16000, 16'd16001, 32'hFF80_7F01, 0, 0, 0);
    send_vertex(16'h7FFF, 16'h8000, 32'h1234_5600, 0, 0, 0);
    wait_drained();
    // Textured modulate, repeat and clamp, blending off, perspective with zero divisor.
    write_all(4'b0011, TFX_HIGHLIGHT, {WRAP_REPEAT, WRAP_CLAMP}, 8'h00, 20'hFFFFF, 20'h0,
              16'h0000, 1'b0);
    send_vertex(16'h1234, 16'h4321, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_vertex(16'd100, 16'd200, 32'h8080_8080, 32'h0001_8000, 32'hFFFF_0000,
                32'h8000_0000);
    send_vertex(16'd5, 16'd5, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
    // Decal, texel mode, size codes 10 and 15, region clamp inverted and region repeat.
    write_all(4'b1111, TFX_DECAL, {WRAP_REG_REPEAT, WRAP_REG_CLAMP}, 8'hFA,
              {10'd3, 10'd900}, {10'h3FF, 10'h3FF}, 16'hFFFF, 1'b1);
    send_vertex(16'd0, 16'd0, 32'h1020_3040, 32'h0100_0000, 32'hFE00_0000, 0);
    send_vertex(16'd0, 16'd0, 32'h1020_3040, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    wait_drained();
    write_reg(REG_TEX_FLAGS, 32'(4'b1011));
    send_vertex(16'd1, 16'd1, 32'hFFFF_FF00, 32'h0, 32'h0, 0);
    wait_drained();
    write_all(4'b0111, TFX_HIGHLIGHT2, {WRAP_REG_REPEAT, WRAP_REG_REPEAT}, 8'h00,
              20'hFFFFF, 20'h00000, 16'h0000, 1'b1);
    send_vertex(16'd1, 16'd1, 32'h7F7F_7F7F, 32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000);
    send_vertex(16'd1, 16'd1, 32'h7F7F_7F7F, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    wait_drained();

    // Random phases over many register settings.
    for (int ph = 0; ph < 15; ph++) begin
      random_config();
      calm_mode = (ph == 7);
      for (int i = 0; i < 50; i++) begin
        // Hold the sender until everything is back.
        if (ph == 3 && i == 25) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_count != 0);
        end
        send_random();
      end
      calm_mode = 1'b0;
      wait_drained();
    end

    $display("Covered %0d vertices over directed and random register settings,",
             sent_count);
    $display("all wrap modes, texel and perspective coordinates, decal and modulate.");
    if (fail_count == 0 && pending_count == 0)
      $display("tb_gs_vertex_attribute_convert: PASS");
    else
      $display("tb_gs_vertex_attribute_convert: FAIL");
    $finish;
  end

  // Guard against a hang.
  initial begin
    #2000000;
    $display("tb_gs_vertex_attribute_convert: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
